// ===== hw/rtl/rti_pkg.sv =====
package rti_pkg;

  localparam int NODES_DEF     = 1024;
  localparam int FEATURES_DEF  = 64;
  localparam int MAX_CAT_DEF   = 32;
  localparam int FRAC_BITS_DEF = 16;

  localparam int ACTION_W   = 2;
  localparam int NODE_IDX_W = 10;
  localparam int FEAT_IDX_W = 6;
  localparam int VALUE_W    = 32;
  localparam int STATUS_W   = 2;
  localparam int MSEL_W     = $clog2(VALUE_W);

  typedef enum logic [ACTION_W-1:0] {
    ACT_NODE_WR = 2'd0,
    ACT_FEAT_WR = 2'd1,
    ACT_PREDICT = 2'd2
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK           = 2'd0,
    ST_BAD_CATEGORY = 2'd1,
    ST_STEP_LIMIT   = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WLINK,
    S_NODE,
    S_FEAT,
    S_DONE
  } state_t;

endpackage

// ===== hw/rtl/rti_if.sv =====
interface rti_in_if import rti_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic [ACTION_W-1:0]          action;
  logic [NODE_IDX_W-1:0]        node_index;
  logic                         node_is_leaf;
  logic                         node_categorical;
  logic [FEAT_IDX_W-1:0]        split_feature;
  logic signed [VALUE_W-1:0]    split_threshold;
  logic [VALUE_W-1:0]           category_mask;
  logic [NODE_IDX_W-1:0]        left_child;
  logic [NODE_IDX_W-1:0]        right_child;
  logic signed [VALUE_W-1:0]    leaf_value;
  logic [FEAT_IDX_W-1:0]        feature_index;
  logic signed [VALUE_W-1:0]    feature_value;

  modport source (
    output valid, action, node_index, node_is_leaf, node_categorical, split_feature,
           split_threshold, category_mask, left_child, right_child, leaf_value,
           feature_index, feature_value,
    input  ready
  );

  modport sink (
    input  valid, action, node_index, node_is_leaf, node_categorical, split_feature,
           split_threshold, category_mask, left_child, right_child, leaf_value,
           feature_index, feature_value,
    output ready
  );
endinterface

interface rti_out_if import rti_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] prediction;
  logic [NODE_IDX_W-1:0]     leaf_node;
  logic [STATUS_W-1:0]       status;

  modport source (output valid, prediction, leaf_node, status, input ready);
  modport sink   (input valid, prediction, leaf_node, status, output ready);
endinterface

// ===== hw/rtl/regression_tree_inference_unit.sv =====
// regression tree inference unit
// in_chan carries one request per handshake (valid/ready): a node table write, a
// sample feature write, or a predict of the current sample. out_chan carries one
// result per predict: leaf value, index of the node where the walk ended, status.
// writes and other actions produce no result.
// a feature write is done on acceptance; a node write is registered first and written
// in S_WLINK (child links are reduced modulo the node count on the way in).
// a predict walks from node 0; each interior node takes one read of the node memory
// followed by one read of the feature memory, and these two reads in series set the
// walk rate. at most NODES interior nodes are visited; after that the walk ends
// with the step-limit status.
// one request is in work at a time; in_chan.ready is high while the unit is idle.
// the result sits in an output register, so a new request is taken while the
// receiver stalls; a later predict holds its result until that register drains.
// rst_n (synchronous, active low) returns the control to idle and drops
// out_chan.valid; memory contents are not cleared and must be written before use.
module regression_tree_inference_unit import rti_pkg::*; #(
  parameter int NODES          = NODES_DEF,
  parameter int FEATURES       = FEATURES_DEF,
  parameter int MAX_CATEGORIES = MAX_CAT_DEF,
  parameter int FRACTION_BITS  = FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  rti_in_if.sink    in_chan,
  rti_out_if.source out_chan
);

  localparam int NAW   = $clog2(NODES);
  localparam int FAW   = (FEATURES > 1) ? $clog2(FEATURES) : 1;
  localparam int STW   = $clog2(NODES + 1);
  localparam int RECIP = ((2 ** 20) + NODES - 1) / NODES;

  typedef struct packed {
    logic                      leaf;
    logic                      categorical;
    logic [FEAT_IDX_W-1:0]     feature;
    logic signed [VALUE_W-1:0] threshold;
    logic [VALUE_W-1:0]        mask;
    logic [NAW-1:0]            right;
    logic [NAW-1:0]            left;
    logic signed [VALUE_W-1:0] leaf_value;
  } node_t;

  node_t                     node_mem [NODES];
  logic signed [VALUE_W-1:0] feat_mem [FEATURES];

  state_t state_r, state_nxt;
  logic [NAW-1:0] k_r, k_nxt;
  logic [STW-1:0] steps_r, steps_nxt;
  logic           feat_oob_r, feat_oob_nxt;
  logic signed [VALUE_W-1:0] res_pred_r, res_pred_nxt;
  status_t        res_status_r, res_status_nxt;

  node_t                     nd_rd_r;
  logic signed [VALUE_W-1:0] ft_rd_r;

  node_t                 wl_entry_r;
  logic [NAW-1:0]        wl_addr_r;
  logic [NODE_IDX_W-1:0] wl_lraw_r, wl_rraw_r, wl_lq_r, wl_rq_r;

  logic                      out_valid_r;
  logic signed [VALUE_W-1:0] out_pred_r;
  logic [NODE_IDX_W-1:0]     out_leaf_r;
  logic [STATUS_W-1:0]       out_status_r;

  logic           in_fire, out_free, out_load;
  action_t        in_act;
  logic [31:0]    in_nidx_ext, in_fidx_ext, lq_prod, rq_prod;
  logic           node_ok, feat_ok;
  logic           nd_re, nd_we, ft_re, ft_we;
  logic [NAW-1:0] nd_raddr;
  node_t          nd_wdata;
  logic [31:0]    wl_lrem, wl_rrem, wl_lfix, wl_rfix;
  logic [31:0]    split_ext, cat_val, cat_m1, k_ext;
  logic           split_ok, cat_range_bad, cat_bad, mask_bit, go_right;
  logic signed [VALUE_W-1:0] fv;
  logic [NAW-1:0] child;
  node_t          wr_entry;

  assign in_fire  = in_chan.valid && in_chan.ready;
  assign in_act   = action_t'(in_chan.action);
  assign out_free = !out_valid_r || out_chan.ready;

  assign in_nidx_ext = 32'(in_chan.node_index);
  assign in_fidx_ext = 32'(in_chan.feature_index);
  assign node_ok     = in_nidx_ext < 32'(NODES);
  assign feat_ok     = in_fidx_ext < 32'(FEATURES);
  assign lq_prod     = 32'(in_chan.left_child) * 32'(RECIP);
  assign rq_prod     = 32'(in_chan.right_child) * 32'(RECIP);

  always_comb begin
    wr_entry             = '0;
    wr_entry.leaf        = in_chan.node_is_leaf;
    wr_entry.categorical = in_chan.node_categorical;
    wr_entry.feature     = in_chan.split_feature;
    wr_entry.threshold   = in_chan.split_threshold;
    wr_entry.mask        = in_chan.category_mask;
    wr_entry.leaf_value  = in_chan.leaf_value;
  end

  // link modulo node count: quotient from the reciprocal, then remainder
  assign wl_lrem = 32'(wl_lraw_r) - 32'(wl_lq_r) * 32'(NODES);
  assign wl_rrem = 32'(wl_rraw_r) - 32'(wl_rq_r) * 32'(NODES);
  assign wl_lfix = (wl_lrem >= 32'(NODES)) ? wl_lrem - 32'(NODES) : wl_lrem;
  assign wl_rfix = (wl_rrem >= 32'(NODES)) ? wl_rrem - 32'(NODES) : wl_rrem;

  always_comb begin
    nd_wdata       = wl_entry_r;
    nd_wdata.left  = wl_lfix[NAW-1:0];
    nd_wdata.right = wl_rfix[NAW-1:0];
  end

  // split evaluation
  assign split_ext     = 32'(nd_rd_r.feature);
  assign split_ok      = split_ext < 32'(FEATURES);
  assign fv            = feat_oob_r ? '0 : ft_rd_r;
  assign cat_val       = 32'(fv) >> FRACTION_BITS;
  assign cat_m1        = cat_val - 32'd1;
  assign cat_range_bad = fv[VALUE_W-1] || (cat_val == '0) ||
                         (cat_val > 32'(MAX_CATEGORIES));
  assign cat_bad       = nd_rd_r.categorical && cat_range_bad;
  assign mask_bit      = nd_rd_r.mask[cat_m1[MSEL_W-1:0]];
  assign go_right      = nd_rd_r.categorical ? !mask_bit : !(fv <= nd_rd_r.threshold);
  assign child         = go_right ? nd_rd_r.right : nd_rd_r.left;
  assign k_ext         = 32'(k_r);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          unique case (in_act)
            ACT_NODE_WR: if (node_ok) state_nxt = S_WLINK;
            ACT_PREDICT: state_nxt = S_NODE;
            default:     state_nxt = S_IDLE;
          endcase
        end
      end
      S_WLINK: state_nxt = S_IDLE;
      S_NODE: begin
        if (nd_rd_r.leaf || (steps_r == STW'(NODES))) state_nxt = S_DONE;
        else state_nxt = S_FEAT;
      end
      S_FEAT: state_nxt = cat_bad ? S_DONE : S_NODE;
      S_DONE: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    k_nxt          = k_r;
    steps_nxt      = steps_r;
    feat_oob_nxt   = feat_oob_r;
    res_pred_nxt   = res_pred_r;
    res_status_nxt = res_status_r;
    nd_re          = 1'b0;
    nd_we          = 1'b0;
    ft_re          = 1'b0;
    ft_we          = 1'b0;
    nd_raddr       = k_r;
    out_load       = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          unique case (in_act)
            ACT_FEAT_WR: ft_we = feat_ok;
            ACT_PREDICT: begin
              nd_re     = 1'b1;
              nd_raddr  = '0;
              k_nxt     = '0;
              steps_nxt = '0;
            end
            default: ;
          endcase
        end
      end
      S_WLINK: nd_we = 1'b1;
      S_NODE: begin
        if (nd_rd_r.leaf) begin
          res_pred_nxt   = nd_rd_r.leaf_value;
          res_status_nxt = ST_OK;
        end else if (steps_r == STW'(NODES)) begin
          res_pred_nxt   = '0;
          res_status_nxt = ST_STEP_LIMIT;
        end else begin
          steps_nxt    = steps_r + STW'(1);
          ft_re        = 1'b1;
          feat_oob_nxt = !split_ok;
        end
      end
      S_FEAT: begin
        if (cat_bad) begin
          res_pred_nxt   = '0;
          res_status_nxt = ST_BAD_CATEGORY;
        end else begin
          k_nxt    = child;
          nd_re    = 1'b1;
          nd_raddr = child;
        end
      end
      S_DONE: out_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      steps_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      steps_r <= steps_nxt;
      if (out_load) out_valid_r <= 1'b1;
      else if (out_chan.ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    k_r          <= k_nxt;
    feat_oob_r   <= feat_oob_nxt;
    res_pred_r   <= res_pred_nxt;
    res_status_r <= res_status_nxt;
    if (state_r == S_IDLE && in_fire) begin
      wl_entry_r <= wr_entry;
      wl_addr_r  <= in_nidx_ext[NAW-1:0];
      wl_lraw_r  <= in_chan.left_child;
      wl_rraw_r  <= in_chan.right_child;
      wl_lq_r    <= lq_prod[29:20];
      wl_rq_r    <= rq_prod[29:20];
    end
    if (out_load) begin
      out_pred_r   <= res_pred_r;
      out_leaf_r   <= k_ext[NODE_IDX_W-1:0];
      out_status_r <= res_status_r;
    end
  end

  always_ff @(posedge clk) begin
    if (nd_we) node_mem[wl_addr_r] <= nd_wdata;
    if (nd_re) nd_rd_r <= node_mem[nd_raddr];
  end

  always_ff @(posedge clk) begin
    if (ft_we) feat_mem[in_fidx_ext[FAW-1:0]] <= in_chan.feature_value;
    if (ft_re) ft_rd_r <= feat_mem[split_ext[FAW-1:0]];
  end

  assign in_chan.ready       = (state_r == S_IDLE);
  assign out_chan.valid      = out_valid_r;
  assign out_chan.prediction = out_pred_r;
  assign out_chan.leaf_node  = out_leaf_r;
  assign out_chan.status     = out_status_r;

  a_steps_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    steps_r <= STW'(NODES))
    else $error("step counter beyond node count");

  a_feat_after_node: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FEAT |-> $past(state_r) == S_NODE)
    else $error("feature evaluation without node fetch");

  a_predict_starts_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_act == ACT_PREDICT) |=> state_r == S_NODE && k_r == '0)
    else $error("predict did not start at root");

  a_links_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_WLINK |-> wl_lfix < 32'(NODES) && wl_rfix < 32'(NODES))
    else $error("child link not reduced");

  a_error_zero_pred: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != ST_OK) |-> out_pred_r == '0)
    else $error("nonzero prediction on error status");

endmodule
